// ===== rtl/core/udlt_pkg.sv =====
`timescale 1ns / 1ps
// udlt_pkg: shared types and constants for the unified diff line tracker.
// No dependencies.
package udlt_pkg;

  // Line kinds as reported on line_kind_o
  localparam logic [2:0] KIND_NEW_HDR = 3'd0;
  localparam logic [2:0] KIND_OLD_HDR = 3'd1;
  localparam logic [2:0] KIND_ADDED   = 3'd2;
  localparam logic [2:0] KIND_REMOVED = 3'd3;
  localparam logic [2:0] KIND_CONTEXT = 3'd4;
  localparam logic [2:0] KIND_HUNK    = 3'd5;
  localparam logic [2:0] KIND_OTHER   = 3'd6;

  // Characters of interest
  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_MINUS   = 8'h2D;
  localparam logic [7:0] CH_AT      = 8'h40;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;

  // Hunk header scan phase
  typedef enum logic [3:0] {
    PH_IDLE  = 4'b0001,
    PH_SCAN  = 4'b0010,
    PH_ORIG  = 4'b0100,
    PH_FINAL = 4'b1000
  } hunk_phase_e;

endpackage

// ===== rtl/core/unified_diff_line_tracker.sv =====
`timescale 1ns / 1ps
// Unified diff line tracker: classifies diff lines and tracks line numbers.
// A newline word shows its result in the cycle after it is accepted.
// Throughput: one text byte per cycle; the state update and the x10 digit
// accumulate sit between the input port and the state/result registers.
// Input stalls only while a result is held and the output is stalled.
// Reset (rst_ni, async low): counters to 1, scanner idle, no result pending.
// Depends on udlt_pkg.
module unified_diff_line_tracker import udlt_pkg::*; #(
  parameter int LINE_NUMBER_BITS = 20
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // input words: one text byte each
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [7:0]                  text_byte_i,
  // result words: one per newline
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [2:0]                  line_kind_o,
  output logic [LINE_NUMBER_BITS-1:0] orig_line_o,
  output logic [LINE_NUMBER_BITS-1:0] final_line_o
);

  localparam int LNB = LINE_NUMBER_BITS;
  localparam logic [LNB-1:0] LN_MAX = {LNB{1'b1}};
  localparam logic [LNB-1:0] LN_ONE = LNB'(1);

  // line state
  logic [1:0]       line_pos_q, line_pos_d;   // bytes seen, saturates at 3
  logic [2:0]       lead_q, lead_d;           // class from first byte
  logic             trip_q, trip_d;           // second and third bytes equal want_ch
  hunk_phase_e      phase_q, phase_d;
  logic [LNB-1:0]   acc_q, acc_d;
  logic [LNB-1:0]   orig_q, orig_d;
  logic [LNB-1:0]   final_q, final_d;

  // result register
  logic             out_valid_q, out_valid_d;
  logic [2:0]       kind_q;
  logic [LNB-1:0]   orig_out_q, final_out_q;

  logic             in_acc, is_nl, is_digit;
  logic [LNB+3:0]   acc_mul;
  logic [LNB-1:0]   acc_sat;
  logic [2:0]       kind_nl;
  logic [LNB-1:0]   orig_nl, final_nl;
  logic [7:0]       want_ch;

  // The output register frees up whenever it is empty or being taken.
  assign in_stall_o = out_valid_q & out_stall_i;
  assign in_acc     = in_valid_i & ~in_stall_o;
  assign is_nl      = (text_byte_i == CH_NEWLINE);
  assign is_digit   = (text_byte_i >= CH_ZERO) && (text_byte_i <= CH_NINE);

  // acc*10 + digit, saturated; 4 extra bits cover the x10 growth
  assign acc_mul = {1'b0, acc_q, 3'b000} + {3'b000, acc_q, 1'b0}
                 + {{LNB{1'b0}}, text_byte_i[3:0]};
  assign acc_sat = (acc_mul > {4'b0000, LN_MAX}) ? LN_MAX : acc_mul[LNB-1:0];

  assign want_ch = (lead_q == KIND_ADDED) ? CH_PLUS : CH_MINUS;

  // newline: kind and counter values after a pending number load
  always_comb begin
    if (line_pos_q == 2'd0) begin
      kind_nl = KIND_OTHER;
    end else begin
      kind_nl = lead_q;
      if (line_pos_q == 2'd3 && trip_q) begin
        if (lead_q == KIND_ADDED) begin
          kind_nl = KIND_NEW_HDR;
        end else if (lead_q == KIND_REMOVED) begin
          kind_nl = KIND_OLD_HDR;
        end
      end
    end
    orig_nl  = (phase_q == PH_ORIG)  ? acc_q : orig_q;
    final_nl = (phase_q == PH_FINAL) ? acc_q : final_q;
  end

  always_comb begin
    line_pos_d = line_pos_q;
    lead_d     = lead_q;
    trip_d     = trip_q;
    phase_d    = phase_q;
    acc_d      = acc_q;
    orig_d     = orig_q;
    final_d    = final_q;
    if (in_acc && is_nl) begin
      line_pos_d = 2'd0;
      lead_d     = 3'd0;
      trip_d     = 1'b0;
      phase_d    = PH_IDLE;
      orig_d     = orig_nl;
      final_d    = final_nl;
      // content lines advance after reporting; counters saturate
      case (kind_nl)
        KIND_CONTEXT: begin
          orig_d  = (orig_nl == LN_MAX) ? LN_MAX : orig_nl + LN_ONE;
          final_d = (final_nl == LN_MAX) ? LN_MAX : final_nl + LN_ONE;
        end
        KIND_ADDED: begin
          final_d = (final_nl == LN_MAX) ? LN_MAX : final_nl + LN_ONE;
        end
        KIND_REMOVED: begin
          orig_d = (orig_nl == LN_MAX) ? LN_MAX : orig_nl + LN_ONE;
        end
        default: begin
        end
      endcase
    end else if (in_acc) begin
      // line classification from the first three bytes
      if (line_pos_q == 2'd0) begin
        if (text_byte_i == CH_PLUS) begin
          lead_d = KIND_ADDED;
        end else if (text_byte_i == CH_MINUS) begin
          lead_d = KIND_REMOVED;
        end else if (text_byte_i == CH_SPACE) begin
          lead_d = KIND_CONTEXT;
        end else if (text_byte_i == CH_AT) begin
          lead_d = KIND_HUNK;
        end else begin
          lead_d = KIND_OTHER;
        end
        trip_d = 1'b1;
      end else if (line_pos_q != 2'd3 && text_byte_i != want_ch) begin
        trip_d = 1'b0;
      end
      // hunk header number scan; a non-digit ending the original number
      // is rescanned as a possible '+' or '-'
      case (phase_q)
        PH_ORIG: begin
          if (is_digit) begin
            acc_d = acc_sat;
          end else begin
            orig_d  = acc_q;
            phase_d = PH_SCAN;
            if (text_byte_i == CH_MINUS) begin
              acc_d   = '0;
              phase_d = PH_ORIG;
            end else if (text_byte_i == CH_PLUS) begin
              acc_d   = '0;
              phase_d = PH_FINAL;
            end
          end
        end
        PH_FINAL: begin
          if (is_digit) begin
            acc_d = acc_sat;
          end else begin
            final_d = acc_q;
            phase_d = PH_IDLE;
          end
        end
        PH_SCAN: begin
          if (text_byte_i == CH_MINUS) begin
            acc_d   = '0;
            phase_d = PH_ORIG;
          end else if (text_byte_i == CH_PLUS) begin
            acc_d   = '0;
            phase_d = PH_FINAL;
          end
        end
        default: begin
        end
      endcase
      // scan starts at the fourth byte of a hunk header
      if (lead_q == KIND_HUNK && line_pos_q == 2'd2) begin
        phase_d = PH_SCAN;
      end
      if (line_pos_q != 2'd3) begin
        line_pos_d = line_pos_q + 2'd1;
      end
    end
  end

  assign out_valid_d = (in_acc & is_nl) | (out_valid_q & out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_pos_q  <= 2'd0;
      lead_q      <= 3'd0;
      trip_q      <= 1'b0;
      phase_q     <= PH_IDLE;
      acc_q       <= '0;
      orig_q      <= LN_ONE;
      final_q     <= LN_ONE;
      out_valid_q <= 1'b0;
    end else begin
      line_pos_q  <= line_pos_d;
      lead_q      <= lead_d;
      trip_q      <= trip_d;
      phase_q     <= phase_d;
      acc_q       <= acc_d;
      orig_q      <= orig_d;
      final_q     <= final_d;
      out_valid_q <= out_valid_d;
    end
  end

  // result payload, loaded only on an accepted newline
  always_ff @(posedge clk_i) begin
    if (in_acc && is_nl) begin
      kind_q      <= kind_nl;
      orig_out_q  <= orig_nl;
      final_out_q <= final_nl;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign line_kind_o  = kind_q;
  assign orig_line_o  = orig_out_q;
  assign final_line_o = final_out_q;

  // checks
  a_phase_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(phase_q))
    else $error("hunk phase not one-hot");

  a_nl_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && is_nl) |=> (phase_q == PH_IDLE && line_pos_q == 2'd0))
    else $error("newline did not clear line state");

  a_rose_from_nl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(in_acc && is_nl))
    else $error("result without newline");

  a_kind_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (kind_q != 3'd7))
    else $error("illegal line kind");

endmodule
